// File: rtl/hsv_to_rgb_converter_assert.svh
// Assertion macros for the HSV to RGBA converter checker.
// Depends on nothing; the using scope provides clk and rst_n.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define H2R_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("h2r port check failed");

// Check cons in the cycle after ante.
`define H2R_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("h2r port check failed");

`endif

// File: rtl/h2r_pkg.sv
// Shared types and constants of the HSV to RGBA converter.
// No dependencies.
`timescale 1ns / 1ps

package h2r_pkg;

    localparam int NUM_STAGES = 5;
    localparam logic [7:0] BYTE_MAX = 8'd255;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

    typedef enum logic [1:0] {
        SRC_V,
        SRC_P,
        SRC_Q,
        SRC_T
    } src_t;

    typedef struct packed {
        src_t r;
        src_t g;
        src_t b;
    } route_t;

    typedef struct packed {
        logic first;
        logic second;
    } stage_en_t;

    function automatic route_t route_of(input sector_t sec);
        route_t rt;
        unique case (sec)
            SEC_RED_YELLOW:   rt = '{r: SRC_V, g: SRC_T, b: SRC_P};
            SEC_YELLOW_GREEN: rt = '{r: SRC_Q, g: SRC_V, b: SRC_P};
            SEC_GREEN_CYAN:   rt = '{r: SRC_P, g: SRC_V, b: SRC_T};
            SEC_CYAN_BLUE:    rt = '{r: SRC_P, g: SRC_Q, b: SRC_V};
            SEC_BLUE_MAGENTA: rt = '{r: SRC_T, g: SRC_P, b: SRC_V};
            default:          rt = '{r: SRC_V, g: SRC_P, b: SRC_Q};
        endcase
        return rt;
    endfunction

endpackage

// File: rtl/hsv_to_rgb_converter.sv
// HSV plus alpha to 8-bit RGBA pixel converter, top level and stage control.
// Depends on h2r_pkg, h2r_sector, h2r_coef and h2r_scale.
//
// The converter takes one HSV+alpha beat per clock while s_tready is high
// and returns one RGBA beat for each, in order. The five register stages
// are: hue sector and alpha byte, saturation times sector position, channel
// coefficient select, value times coefficient, clamp and round to bytes.
// Each stage holds its beat while the next one is full and cannot advance,
// so bubbles close up under back-pressure and up to five beats are in
// flight; s_tready drops only when every stage is full and m_tready is low.
`timescale 1ns / 1ps

module hsv_to_rgb_converter #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // hue, saturation, brightness, opacity; zero padded to whole bytes
    input  logic [((4*FRACTION_BITS+3+7)/8)*8-1:0]      s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // red, green, blue, alpha_out
    output logic [31:0]                                 m_tdata
);

    localparam int F = FRACTION_BITS;
    localparam int N = h2r_pkg::NUM_STAGES;

    logic [N-1:0]           vld_reg;
    logic [N-1:0]           vld_next;
    logic [N-1:0]           vld_in;
    logic [N:0]             rdy;
    logic [N-1:0]           load;

    logic [F-1:0]           hue;
    logic [F:0]             saturation;
    logic [F:0]             brightness;
    logic [F:0]             opacity;

    h2r_pkg::sector_t       s1_sector;
    logic [F-1:0]           s1_pos;
    logic [F:0]             s1_sat;
    logic [F:0]             s1_val;
    logic [7:0]             s1_alpha;

    logic signed [F+2:0]    s3_coef_r;
    logic signed [F+2:0]    s3_coef_g;
    logic signed [F+2:0]    s3_coef_b;
    logic [F:0]             s3_val;
    logic [7:0]             s3_alpha;

    h2r_pkg::stage_en_t     coef_en;
    h2r_pkg::stage_en_t     scale_en;

    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [7:0]             alpha_out;

    assign hue        = s_tdata[F-1:0];
    assign saturation = s_tdata[2*F:F];
    assign brightness = s_tdata[3*F+1:2*F+1];
    assign opacity    = s_tdata[4*F+2:3*F+2];

    // Advance a stage when it is empty or its successor advances.
    always_comb
    begin
        rdy[N] = m_tready;
        for (int k = N - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        vld_in[0] = s_tvalid;
        for (int k = 1; k < N; k++)
        begin
            vld_in[k] = vld_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            load[k]     = rdy[k] && vld_in[k];
            vld_next[k] = rdy[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign coef_en  = '{first: load[1], second: load[2]};
    assign scale_en = '{first: load[3], second: load[4]};

    h2r_sector #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_sector (
        .clk        (clk),
        .en         (load[0]),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .opacity    (opacity),
        .sector     (s1_sector),
        .pos        (s1_pos),
        .sat_out    (s1_sat),
        .val_out    (s1_val),
        .alpha_byte (s1_alpha)
    );

    h2r_coef #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_coef (
        .clk       (clk),
        .en        (coef_en),
        .sector    (s1_sector),
        .pos       (s1_pos),
        .sat_in    (s1_sat),
        .val_in    (s1_val),
        .alpha_in  (s1_alpha),
        .coef_r    (s3_coef_r),
        .coef_g    (s3_coef_g),
        .coef_b    (s3_coef_b),
        .val_out   (s3_val),
        .alpha_out (s3_alpha)
    );

    h2r_scale #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_scale (
        .clk       (clk),
        .en        (scale_en),
        .coef_r    (s3_coef_r),
        .coef_g    (s3_coef_g),
        .coef_b    (s3_coef_b),
        .val_in    (s3_val),
        .alpha_in  (s3_alpha),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha_out (alpha_out)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[N-1];
    assign m_tdata  = {alpha_out, blue, green, red};

endmodule

// File: rtl/h2r_sector.sv
// Stage 1: hue times six into sector and position, alpha to a byte.
// Depends on h2r_pkg.
`timescale 1ns / 1ps

module h2r_sector #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [FRACTION_BITS-1:0]  hue,
    input  logic [FRACTION_BITS:0]    saturation,
    input  logic [FRACTION_BITS:0]    brightness,
    input  logic [FRACTION_BITS:0]    opacity,
    output h2r_pkg::sector_t          sector,
    output logic [FRACTION_BITS-1:0]  pos,
    output logic [FRACTION_BITS:0]    sat_out,
    output logic [FRACTION_BITS:0]    val_out,
    output logic [7:0]                alpha_byte
);

    localparam int F = FRACTION_BITS;
    localparam logic [F+7:0] HALF = (F+8)'(1) << (F - 1);

    logic [F+2:0]           h6;
    logic [F+7:0]           a_scaled;
    logic [7:0]             alpha_next;

    h2r_pkg::sector_t       sector_reg;
    logic [F-1:0]           pos_reg;
    logic [F:0]             sat_reg;
    logic [F:0]             val_reg;
    logic [7:0]             alpha_reg;

    assign h6       = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    assign a_scaled = {opacity[F-1:0], 8'd0} - {8'd0, opacity[F-1:0]} + HALF;

    always_comb
    begin
        if (opacity == '0)
        begin
            alpha_next = 8'd0;
        end
        else if (opacity[F])
        begin
            alpha_next = h2r_pkg::BYTE_MAX;
        end
        else
        begin
            alpha_next = a_scaled[F+7:F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector_reg <= h2r_pkg::sector_t'(h6[F+2:F]);
            pos_reg    <= h6[F-1:0];
            sat_reg    <= saturation;
            val_reg    <= brightness;
            alpha_reg  <= alpha_next;
        end
    end

    assign sector     = sector_reg;
    assign pos        = pos_reg;
    assign sat_out    = sat_reg;
    assign val_out    = val_reg;
    assign alpha_byte = alpha_reg;

endmodule

// File: rtl/h2r_coef.sv
// Stages 2 and 3: saturation times position, then per-channel coefficient.
// Depends on h2r_pkg.
`timescale 1ns / 1ps

module h2r_coef #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  h2r_pkg::stage_en_t              en,
    input  h2r_pkg::sector_t                sector,
    input  logic [FRACTION_BITS-1:0]        pos,
    input  logic [FRACTION_BITS:0]          sat_in,
    input  logic [FRACTION_BITS:0]          val_in,
    input  logic [7:0]                      alpha_in,
    output logic signed [FRACTION_BITS+2:0] coef_r,
    output logic signed [FRACTION_BITS+2:0] coef_g,
    output logic signed [FRACTION_BITS+2:0] coef_b,
    output logic [FRACTION_BITS:0]          val_out,
    output logic [7:0]                      alpha_out
);

    localparam int F  = FRACTION_BITS;
    localparam int CW = F + 3;
    localparam logic signed [CW-1:0] ONE_C = CW'(1) << F;

    logic [2*F:0]               sf_prod;

    h2r_pkg::sector_t           sector_reg;
    logic [F:0]                 sf_reg;
    logic [F:0]                 sat_reg;
    logic [F:0]                 val_a_reg;
    logic [7:0]                 alpha_a_reg;

    logic signed [CW-1:0]       s_ext;
    logic signed [CW-1:0]       sf_ext;
    logic signed [CW-1:0]       cp;
    logic signed [CW-1:0]       cq;
    logic signed [CW-1:0]       ct;
    h2r_pkg::route_t            rt;
    logic signed [CW-1:0]       coef_r_next;
    logic signed [CW-1:0]       coef_g_next;
    logic signed [CW-1:0]       coef_b_next;

    logic signed [CW-1:0]       coef_r_reg;
    logic signed [CW-1:0]       coef_g_reg;
    logic signed [CW-1:0]       coef_b_reg;
    logic [F:0]                 val_b_reg;
    logic [7:0]                 alpha_b_reg;

    function automatic logic signed [CW-1:0] pick(
        input h2r_pkg::src_t        src,
        input logic signed [CW-1:0] vp,
        input logic signed [CW-1:0] vq,
        input logic signed [CW-1:0] vt
    );
        logic signed [CW-1:0] res;
        unique case (src)
            h2r_pkg::SRC_V: res = ONE_C;
            h2r_pkg::SRC_P: res = vp;
            h2r_pkg::SRC_Q: res = vq;
            h2r_pkg::SRC_T: res = vt;
            default:        res = ONE_C;
        endcase
        return res;
    endfunction

    assign sf_prod = (2*F+1)'(sat_in) * (2*F+1)'(pos);

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            sector_reg  <= sector;
            sf_reg      <= sf_prod[2*F:F];
            sat_reg     <= sat_in;
            val_a_reg   <= val_in;
            alpha_a_reg <= alpha_in;
        end
    end

    assign s_ext  = $signed({2'b00, sat_reg});
    assign sf_ext = $signed({2'b00, sf_reg});
    assign cp     = ONE_C - s_ext;
    assign cq     = ONE_C - sf_ext;
    assign ct     = cp + sf_ext;
    assign rt     = h2r_pkg::route_of(sector_reg);

    assign coef_r_next = pick(rt.r, cp, cq, ct);
    assign coef_g_next = pick(rt.g, cp, cq, ct);
    assign coef_b_next = pick(rt.b, cp, cq, ct);

    always_ff @(posedge clk)
    begin
        if (en.second)
        begin
            coef_r_reg  <= coef_r_next;
            coef_g_reg  <= coef_g_next;
            coef_b_reg  <= coef_b_next;
            val_b_reg   <= val_a_reg;
            alpha_b_reg <= alpha_a_reg;
        end
    end

    assign coef_r    = coef_r_reg;
    assign coef_g    = coef_g_reg;
    assign coef_b    = coef_b_reg;
    assign val_out   = val_b_reg;
    assign alpha_out = alpha_b_reg;

endmodule

// File: rtl/h2r_scale.sv
// Stages 4 and 5: value times coefficient, then clamp and round to bytes.
// Depends on h2r_pkg.
`timescale 1ns / 1ps

module h2r_scale #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  h2r_pkg::stage_en_t              en,
    input  logic signed [FRACTION_BITS+2:0] coef_r,
    input  logic signed [FRACTION_BITS+2:0] coef_g,
    input  logic signed [FRACTION_BITS+2:0] coef_b,
    input  logic [FRACTION_BITS:0]          val_in,
    input  logic [7:0]                      alpha_in,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic [7:0]                      alpha_out
);

    localparam int F  = FRACTION_BITS;
    localparam int PW = 2 * F + 5;
    localparam logic [2*F+7:0] HALF = (2*F+8)'(1) << (2*F - 1);

    logic signed [F+1:0]    v_ext;
    logic signed [PW-1:0]   prod_r_next;
    logic signed [PW-1:0]   prod_g_next;
    logic signed [PW-1:0]   prod_b_next;

    logic signed [PW-1:0]   prod_r_reg;
    logic signed [PW-1:0]   prod_g_reg;
    logic signed [PW-1:0]   prod_b_reg;
    logic [7:0]             alpha_c_reg;

    logic [7:0]             red_reg;
    logic [7:0]             green_reg;
    logic [7:0]             blue_reg;
    logic [7:0]             alpha_d_reg;

    function automatic logic [7:0] to_byte(input logic signed [PW-1:0] x);
        logic [2*F+7:0] u;
        logic [7:0]     res;
        u = {x[2*F-1:0], 8'd0} - {8'd0, x[2*F-1:0]} + HALF;
        if (x[PW-1] || (x == '0))
        begin
            res = 8'd0;
        end
        else if (x[PW-2:2*F] != '0)
        begin
            res = h2r_pkg::BYTE_MAX;
        end
        else
        begin
            res = u[2*F+7:2*F];
        end
        return res;
    endfunction

    assign v_ext       = $signed({1'b0, val_in});
    assign prod_r_next = v_ext * coef_r;
    assign prod_g_next = v_ext * coef_g;
    assign prod_b_next = v_ext * coef_b;

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            prod_r_reg  <= prod_r_next;
            prod_g_reg  <= prod_g_next;
            prod_b_reg  <= prod_b_next;
            alpha_c_reg <= alpha_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.second)
        begin
            red_reg     <= to_byte(prod_r_reg);
            green_reg   <= to_byte(prod_g_reg);
            blue_reg    <= to_byte(prod_b_reg);
            alpha_d_reg <= alpha_c_reg;
        end
    end

    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha_out = alpha_d_reg;

endmodule

// File: rtl/h2r_checker.sv
// Port-level checker for the HSV to RGBA converter, bound to the top level.
// Depends on h2r_pkg and hsv_to_rgb_converter_assert.svh.
`timescale 1ns / 1ps

`include "hsv_to_rgb_converter_assert.svh"

module h2r_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    localparam int N  = h2r_pkg::NUM_STAGES;
    localparam int CW = $clog2(N + 1);

    logic          in_beat;
    logic          out_beat;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;
    assign cnt_next = cnt_reg + CW'(in_beat) - CW'(out_beat);

    // Track beats in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `H2R_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `H2R_ASSERT_NOW(a_no_phantom, cnt_reg == '0, !m_tvalid)
    `H2R_ASSERT_NOW(a_depth, 1'b1, cnt_reg <= CW'(N))
    `H2R_ASSERT_NOW(a_full_stall, (cnt_reg == CW'(N)) && !m_tready, !s_tready)

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/testbench.sv
// Self-checking bench for the HSV plus alpha to RGBA pixel converter.
// Depends on h2r_pkg and hsv_to_rgb_converter; drives the stream ports and scores each pixel.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_W = 16;
    localparam longint ONE = longint'(1) << FRAC_W;
    localparam int S_DATA_W = ((4 * FRAC_W + 3 + 7) / 8) * 8;
    localparam int RANDOM_BEATS = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 2 * h2r_pkg::NUM_STAGES;
    localparam int NUM_ROWS = 22;

    typedef struct {
        logic [15:0] hue;
        logic [16:0] saturation;
        logic [16:0] brightness;
        logic [16:0] opacity;
    } hsv_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_out;
    } pixel_t;

    typedef struct {
        hsv_t   color;
        bit     known;
        pixel_t pix;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // hue, saturation, brightness, opacity, zero pad
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // red, green, blue, alpha_out
    logic [31:0]         m_tdata;

    pixel_t pending_pixels[$];
    int     mismatches = 0;
    int     cycles = 0;
    int     send_idle_pct;
    int     recv_idle_pct;
    pixel_t got_pix;
    pixel_t want_pix;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{'{16'd0, 17'd0, 17'd0, 17'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd0, 17'd0, 17'd65536, 17'd65536}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{'{16'd0, 17'd65536, 17'd65536, 17'd65536}, 1'b1, '{8'd255, 8'd0, 8'd0, 8'd255}},
        '{'{16'd32768, 17'd65536, 17'd65536, 17'd65536}, 1'b1,
          '{8'd0, 8'd255, 8'd255, 8'd255}},
        '{'{16'd0, 17'h1FFFF, 17'd65536, 17'd0}, 1'b1, '{8'd255, 8'd0, 8'd0, 8'd0}},
        '{'{16'd0, 17'd0, 17'h1FFFF, 17'h1FFFF}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{'{16'd0, 17'd0, 17'd0, 17'd32768}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd128}},
        '{'{16'd0, 17'd0, 17'd0, 17'd1}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd10922, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd10923, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd21845, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd21846, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd32767, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd43690, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd43691, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd54613, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd54614, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd65535, 17'd65536, 17'd65536, 17'd65536}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'hAAAA, 17'h15555, 17'h0AAAA, 17'h15555}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'h5555, 17'h0AAAA, 17'h15555, 17'h0AAAA}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'hFFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd20000, 17'd32768, 17'd49152, 17'd65535}, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}}
    };

    hsv_to_rgb_converter #(
        .FRACTION_BITS(FRAC_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic logic [7:0] round_to_byte(longint x, int k);
        longint unsigned u;
        if (x <= 0)
        begin
            return 8'd0;
        end
        if (x >= (longint'(1) << k))
        begin
            return 8'd255;
        end
        u = longint'(x) * 255 + (longint'(1) << (k - 1));
        return 8'(u >> k);
    endfunction

    function automatic pixel_t hsv_to_pixel(hsv_t c);
        longint           h6;
        longint           f;
        longint           s;
        longint           v;
        longint           sf;
        longint           p;
        longint           q;
        longint           t;
        longint           vv;
        longint           r;
        longint           g;
        longint           b;
        h2r_pkg::sector_t sec;
        pixel_t           px;
        h6  = longint'(c.hue) * 6;
        sec = h2r_pkg::sector_t'(3'(h6 >> FRAC_W));
        f   = h6 & (ONE - 1);
        s   = longint'(c.saturation);
        v   = longint'(c.brightness);
        sf  = (s * f) >> FRAC_W;
        p   = v * (ONE - s);
        q   = v * (ONE - sf);
        t   = v * (ONE - s + sf);
        vv  = v * ONE;
        case (sec)
            h2r_pkg::SEC_RED_YELLOW:
            begin
                r = vv; g = t;  b = p;
            end
            h2r_pkg::SEC_YELLOW_GREEN:
            begin
                r = q;  g = vv; b = p;
            end
            h2r_pkg::SEC_GREEN_CYAN:
            begin
                r = p;  g = vv; b = t;
            end
            h2r_pkg::SEC_CYAN_BLUE:
            begin
                r = p;  g = q;  b = vv;
            end
            h2r_pkg::SEC_BLUE_MAGENTA:
            begin
                r = t;  g = p;  b = vv;
            end
            default:
            begin
                r = vv; g = p;  b = q;
            end
        endcase
        px.red       = round_to_byte(r, 2 * FRAC_W);
        px.green     = round_to_byte(g, 2 * FRAC_W);
        px.blue      = round_to_byte(b, 2 * FRAC_W);
        px.alpha_out = round_to_byte(longint'(c.opacity), FRAC_W);
        return px;
    endfunction

    function automatic logic [16:0] pick_level();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            3, 4: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [15:0] pick_hue();
        int edge_idx;
        if ($urandom_range(0, 7) != 0)
        begin
            return 16'($urandom_range(0, 65535));
        end
        // land on or next to a sector boundary
        edge_idx = $urandom_range(0, 6);
        return 16'((edge_idx * 65536 + 5) / 6 + $urandom_range(0, 2) - 1);
    endfunction

    task automatic send_color(hsv_t c, bit known, pixel_t typed_pix);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, c.opacity, c.brightness, c.saturation, c.hue};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_pixels.push_back(known ? typed_pix : hsv_to_pixel(c));
    endtask

    task automatic drain_pending();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("hsv_to_rgb_converter: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_pix = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]};
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected pixel r=%0d g=%0d b=%0d a=%0d", got_pix.red,
                             got_pix.green, got_pix.blue, got_pix.alpha_out);
                end
            end
            else
            begin
                want_pix = pending_pixels.pop_front();
                if (got_pix.red != want_pix.red || got_pix.green != want_pix.green ||
                    got_pix.blue != want_pix.blue || got_pix.alpha_out != want_pix.alpha_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("pixel exp r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
                                 want_pix.red, want_pix.green, want_pix.blue,
                                 want_pix.alpha_out, got_pix.red, got_pix.green,
                                 got_pix.blue, got_pix.alpha_out);
                    end
                end
            end
        end
    end

    initial
    begin
        hsv_t   c;
        pixel_t none_pix;
        send_idle_pct = 37;
        recv_idle_pct = 46;
        none_pix      = '{8'd0, 8'd0, 8'd0, 8'd0};
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            send_color(directed_rows[i].color, directed_rows[i].known, directed_rows[i].pix);
        end
        // hold off until the pipeline is empty
        drain_pending();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 37 : 0;
            for (int n = 0; n < RANDOM_BEATS / 3; n++)
            begin
                c.hue        = pick_hue();
                c.saturation = pick_level();
                c.brightness = pick_level();
                c.opacity    = pick_level();
                send_color(c, 1'b0, none_pix);
            end
            drain_pending();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
        begin
            $display("hsv_to_rgb_converter: match");
        end
        else
        begin
            $display("hsv_to_rgb_converter: mismatch");
        end
        $finish;
    end

endmodule

// File: hsv_to_rgb_converter.f
+incdir+rtl
rtl/h2r_pkg.sv
rtl/h2r_sector.sv
rtl/h2r_coef.sv
rtl/h2r_scale.sv
rtl/hsv_to_rgb_converter.sv
rtl/h2r_checker.sv
bench/testbench.sv
